>>> src/lz77d_pkg.sv
// ---------------------------------------------------------------------------
// lz77d_pkg
// shared types and constants for the lz77 variant decompressor
// ---------------------------------------------------------------------------
package lz77d_pkg;

  localparam int unsigned WindowBytes = 8192;
  localparam int unsigned PtrW = $clog2(WindowBytes);
  localparam int unsigned CntW = PtrW + 1;

  typedef enum logic [3:0] {
    PH_CTRL = 4'd0,
    PH_LIT  = 4'd1,
    PH_COPY = 4'd2,
    PH_DIST = 4'd3,
    PH_SEL  = 4'd4,
    PH_C4A  = 4'd5,
    PH_C4B  = 4'd6,
    PH_C4C  = 4'd7,
    PH_CNT1 = 4'd8
  } phase_t;

  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
    logic       last_of_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       wants_input;
    logic       error_flag;
  } out_item_t;

  // history read and write request from the parser to the memory
  typedef struct packed {
    logic            we;
    logic [PtrW-1:0] waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [PtrW-1:0] raddr;
  } hist_req_t;

endpackage

>>> src/lz77d_ram.sv
// ---------------------------------------------------------------------------
// lz77d_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module lz77d_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/lz77d_parser.sv
// ---------------------------------------------------------------------------
// lz77d_parser
// token parser, copy sequencer and result stage of the decompressor
// ---------------------------------------------------------------------------
module lz77d_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lz77d_pkg::in_item_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lz77d_pkg::out_item_t   out_data,
  output lz77d_pkg::hist_req_t   hreq,
  input  logic [7:0]             hrdata
);

  localparam int unsigned PtrW = lz77d_pkg::PtrW;
  localparam int unsigned CntW = lz77d_pkg::CntW;

  lz77d_pkg::phase_t phase_r, phase_nxt;
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [CntW-1:0] prod_r, prod_nxt;
  logic [7:0]      ctrl_r, ctrl_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [CntW-1:0] dist_r, dist_nxt;
  logic            bend_r, bend_nxt;
  logic            err_r, err_nxt;

  // stage 1: history read in flight, result completed by the output register
  logic            s1_vld_r;
  logic            s1_copy_r;
  logic [7:0]      s1_lit_r;
  logic            s1_ovalid_r;
  lz77d_pkg::out_item_t s1_item_r;
  // forwarding of the byte written in the same cycle as the read
  logic            fwd_r;
  logic [7:0]      fwd_byte_r;
  logic [7:0]      fwd_data_nxt;

  // output register
  logic                 ob_vld_r;
  lz77d_pkg::out_item_t ob_r;
  lz77d_pkg::out_item_t ob_nxt;

  logic adv;
  logic acc;
  logic [7:0] b;
  logic [7:0] s1_byte;
  logic       valid_c, olast_c;
  logic       rd_copy;
  logic [CntW-1:0] d_new;
  logic       d_set;
  logic [32:0] r_new;
  logic       want_copy;
  logic [32:0] rem_shift;

  assign adv      = !ob_vld_r || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;
  assign b        = in_data.in_byte;

  assign s1_byte = s1_copy_r ? (fwd_r ? fwd_byte_r : hrdata) : s1_lit_r;

  assign rem_shift = {1'b0, rem_r[23:0], b};

  always_comb begin
    phase_nxt = phase_r;
    wptr_nxt  = wptr_r;
    prod_nxt  = prod_r;
    ctrl_nxt  = ctrl_r;
    rem_nxt   = rem_r;
    dist_nxt  = dist_r;
    bend_nxt  = bend_r;
    err_nxt   = err_r;
    valid_c   = 1'b0;
    olast_c   = 1'b0;
    rd_copy   = 1'b0;
    d_set     = 1'b0;
    d_new     = dist_r;
    r_new     = rem_r;
    want_copy = 1'b0;
    fwd_data_nxt = s1_byte;
    if (acc) begin
      if (in_data.opcode == lz77d_pkg::OP_DRAIN) begin
        if (phase_r == lz77d_pkg::PH_COPY) begin
          valid_c = 1'b1;
          rd_copy = 1'b1;
          rem_nxt = rem_r - 33'd1;
          if (rem_r == 33'd1) begin
            phase_nxt = lz77d_pkg::PH_CTRL;
            if (bend_r) begin
              olast_c = 1'b1;
            end
          end
        end
      end else if (phase_r == lz77d_pkg::PH_COPY) begin
        err_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          lz77d_pkg::PH_LIT: begin
            valid_c = 1'b1;
            rem_nxt = rem_r - 33'd1;
            if (rem_r == 33'd1) begin
              phase_nxt = lz77d_pkg::PH_CTRL;
            end
          end
          lz77d_pkg::PH_DIST: begin
            if (ctrl_r[7]) begin
              r_new = 33'(ctrl_r[6:5]) + 33'd3;
              d_set = 1'b1;
              d_new = CntW'({ctrl_r[4:0], b}) + CntW'(1);
              want_copy = 1'b1;
            end else if (ctrl_r[6:5] == 2'd2) begin
              r_new = 33'(ctrl_r[4:0]) + 33'd7;
              d_set = 1'b1;
              d_new = CntW'(b) + CntW'(1);
              want_copy = 1'b1;
            end else begin
              dist_nxt  = CntW'({ctrl_r[4:0], b}) + CntW'(1);
              phase_nxt = lz77d_pkg::PH_SEL;
            end
          end
          lz77d_pkg::PH_SEL: begin
            rem_nxt = '0;
            if (b == 8'hFE) begin
              ctrl_nxt  = 8'hFE;
              phase_nxt = lz77d_pkg::PH_C4C;
            end else if (b == 8'hFF) begin
              ctrl_nxt  = 8'hFF;
              phase_nxt = lz77d_pkg::PH_C4A;
            end else begin
              r_new = 33'(b) + 33'd7;
              want_copy = 1'b1;
            end
          end
          lz77d_pkg::PH_C4A, lz77d_pkg::PH_C4B, lz77d_pkg::PH_C4C: begin
            rem_nxt   = rem_shift;
            phase_nxt = lz77d_pkg::phase_t'(phase_r + 4'd1);
          end
          lz77d_pkg::PH_CNT1: begin
            if (ctrl_r == 8'h1D) begin
              r_new = rem_shift + 33'h1E;
            end else if (ctrl_r == 8'h1E) begin
              r_new = rem_shift + 33'h11E;
            end else if (ctrl_r == 8'h1F) begin
              r_new = rem_shift;
            end else if (ctrl_r == 8'hFE) begin
              r_new = rem_shift + 33'h105;
              want_copy = 1'b1;
            end else begin
              r_new = rem_shift + 33'd3;
              want_copy = 1'b1;
            end
            if (!want_copy) begin
              rem_nxt   = r_new;
              phase_nxt = (r_new != '0) ? lz77d_pkg::PH_LIT : lz77d_pkg::PH_CTRL;
            end
          end
          default: begin
            ctrl_nxt = b;
            rem_nxt  = '0;
            if (b < 8'h1D) begin
              rem_nxt   = 33'(b) + 33'd1;
              phase_nxt = lz77d_pkg::PH_LIT;
            end else if (b == 8'h1D) begin
              phase_nxt = lz77d_pkg::PH_CNT1;
            end else if (b == 8'h1E) begin
              phase_nxt = lz77d_pkg::PH_C4C;
            end else if (b == 8'h1F) begin
              phase_nxt = lz77d_pkg::PH_C4A;
            end else if (b[7:5] == 3'd1) begin
              r_new = 33'(b[1:0]) + 33'd3;
              d_set = 1'b1;
              d_new = CntW'(b[4:2]) + CntW'(1);
              want_copy = 1'b1;
            end else begin
              phase_nxt = lz77d_pkg::PH_DIST;
            end
          end
        endcase
        if (want_copy) begin
          if (d_set) begin
            dist_nxt = d_new;
          end
          if (d_new == '0 || d_new > prod_r) begin
            err_nxt   = 1'b1;
            rem_nxt   = '0;
            phase_nxt = lz77d_pkg::PH_CTRL;
          end else begin
            rem_nxt   = r_new;
            phase_nxt = lz77d_pkg::PH_COPY;
          end
        end
        if (in_data.last_of_block) begin
          if (phase_nxt == lz77d_pkg::PH_COPY) begin
            bend_nxt = 1'b1;
          end else begin
            if (phase_nxt != lz77d_pkg::PH_CTRL) begin
              err_nxt = 1'b1;
            end
            olast_c = valid_c;
          end
        end
      end
      if (valid_c) begin
        wptr_nxt = wptr_r + PtrW'(1);
        if (prod_r < CntW'(lz77d_pkg::WindowBytes)) begin
          prod_nxt = prod_r + CntW'(1);
        end
      end
      if ((in_data.opcode == lz77d_pkg::OP_FEED && in_data.last_of_block &&
           phase_r != lz77d_pkg::PH_COPY && phase_nxt != lz77d_pkg::PH_COPY) ||
          olast_c) begin
        wptr_nxt  = '0;
        prod_nxt  = '0;
        phase_nxt = lz77d_pkg::PH_CTRL;
        rem_nxt   = '0;
        bend_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    ob_nxt = s1_item_r;
    ob_nxt.out_byte = s1_ovalid_r ? s1_byte : 8'd0;
  end

  // a copy read and its write of the previous byte share an address only at distance 1
  assign hreq.re    = rd_copy;
  assign hreq.raddr = wptr_r - dist_r[PtrW-1:0];
  assign hreq.we    = s1_vld_r && s1_ovalid_r;
  assign hreq.wdata = s1_byte;
  assign hreq.waddr = wptr_r - PtrW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lz77d_pkg::PH_CTRL;
      wptr_r   <= '0;
      prod_r   <= '0;
      ctrl_r   <= '0;
      rem_r    <= '0;
      dist_r   <= '0;
      bend_r   <= 1'b0;
      err_r    <= 1'b0;
      s1_vld_r <= 1'b0;
      ob_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        wptr_r  <= wptr_nxt;
        prod_r  <= prod_nxt;
        ctrl_r  <= ctrl_nxt;
        rem_r   <= rem_nxt;
        dist_r  <= dist_nxt;
        bend_r  <= bend_nxt;
        err_r   <= err_nxt;
      end
      if (adv) begin
        s1_vld_r <= acc;
        ob_vld_r <= s1_vld_r;
        fwd_r    <= rd_copy && s1_vld_r && s1_ovalid_r && dist_r == CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_copy_r   <= rd_copy;
      s1_lit_r    <= b;
      s1_ovalid_r <= valid_c;
      fwd_byte_r  <= fwd_data_nxt;
      s1_item_r.out_byte    <= '0;
      s1_item_r.out_valid   <= valid_c;
      s1_item_r.out_last    <= olast_c;
      s1_item_r.wants_input <= (phase_nxt != lz77d_pkg::PH_COPY);
      s1_item_r.error_flag  <= err_nxt;
      if (s1_vld_r) begin
        ob_r <= ob_nxt;
      end
    end
  end

  assign out_valid = ob_vld_r;
  assign out_data  = ob_r;

endmodule

>>> src/lz77_variant_decompressor.sv
// ---------------------------------------------------------------------------
// lz77_variant_decompressor
// byte-oriented lz77 variant decoder with an 8 KiB history
// ---------------------------------------------------------------------------
// in_valid/in_ready/in_data carry one item: a compressed byte to feed or a
// drain request for one pending copy byte. Every accepted item yields exactly
// one result on out_valid/out_ready/out_data, carrying the decoded byte (if
// any), the block-end marker, whether the next item should feed, and the
// sticky error.
// Between input transfer and result the item passes the history memory read
// stage, then the output register. One item is taken each cycle while the
// receiver does not stall; the single-port-read history ram sets that rate,
// one read and one write per cycle, with a bypass for distance-one copies.
// Synchronous reset clears the parser, pointers and error; history contents
// stay undefined until written and are never read before.
// When the receiver stalls, in_ready drops in the same cycle and the pipe
// holds its contents until the result is taken.
// ---------------------------------------------------------------------------
module lz77_variant_decompressor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lz77d_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lz77d_pkg::out_item_t out_data
);

  lz77d_pkg::hist_req_t hreq;
  logic [7:0]           hrdata;

  lz77d_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .hreq     (hreq),
    .hrdata   (hrdata)
  );

  lz77d_ram #(
    .Width(8),
    .Depth(lz77d_pkg::WindowBytes)
  ) u_hist (
    .clk  (clk),
    .we   (hreq.we),
    .waddr(hreq.waddr),
    .wdata(hreq.wdata),
    .re   (hreq.re),
    .raddr(hreq.raddr),
    .rdata(hrdata)
  );

endmodule

>>> src/lz77d_checker.sv
// ---------------------------------------------------------------------------
// lz77d_checker
// port-level checks for the lz77 variant decompressor
// ---------------------------------------------------------------------------
module lz77d_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input lz77d_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.error_flag |=>
      !out_valid || out_data.error_flag)
    else $error("error flag cleared");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_last |-> out_data.out_valid)
    else $error("last without byte");

  a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_valid |-> out_data.out_byte == 8'd0)
    else $error("byte without valid");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no result waiting");

endmodule

bind lz77_variant_decompressor lz77d_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> tb/sv/tb_lz77_variant_decompressor.sv
// ---------------------------------------------------------------------------
// tb_lz77_variant_decompressor
// self-checking bench for the lz77 variant decoder: directed token sequences
// then random well-formed blocks with some noise, random stalls on both
// sides, each result checked against an in-bench decoder model
// ---------------------------------------------------------------------------
module tb_lz77_variant_decompressor;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lz77d_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lz77d_pkg::out_item_t out_data;

  lz77_variant_decompressor dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  // decoder model state
  logic [7:0]  hist_mem [lz77d_pkg::WindowBytes];
  logic [12:0] wr_ptr;
  logic [13:0] produced;
  lz77d_pkg::phase_t phase;
  logic [7:0]  ctrl_b;
  logic [32:0] remain;
  logic [13:0] cp_dist;
  logic        ending;
  logic        err;

  lz77d_pkg::in_item_t  pending_items[$];
  lz77d_pkg::out_item_t expected_results[$];
  int        fail_count = 0;
  bit        quiet = 1'b0;
  bit        stim_done = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void block_reset();
    wr_ptr = '0;
    produced = '0;
    phase = lz77d_pkg::PH_CTRL;
    remain = '0;
    ending = 1'b0;
  endfunction

  function automatic void hist_put(input logic [7:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 13'd1;
    if (produced < 14'(lz77d_pkg::WindowBytes)) produced++;
  endfunction

  function automatic void start_copy();
    if (cp_dist == '0 || cp_dist > produced) begin
      err = 1'b1;
      remain = '0;
      phase = lz77d_pkg::PH_CTRL;
    end else begin
      phase = lz77d_pkg::PH_COPY;
    end
  endfunction

  function automatic void start_literal();
    phase = (remain != '0) ? lz77d_pkg::PH_LIT : lz77d_pkg::PH_CTRL;
  endfunction

  function automatic lz77d_pkg::out_item_t decode_item(input lz77d_pkg::in_item_t it);
    lz77d_pkg::out_item_t r;
    logic [7:0] b, c;
    r = '0;
    b = it.in_byte;
    if (it.opcode == lz77d_pkg::OP_DRAIN) begin
      if (phase == lz77d_pkg::PH_COPY) begin
        r.out_byte = hist_mem[wr_ptr - cp_dist[12:0]];
        r.out_valid = 1'b1;
        hist_put(r.out_byte);
        remain--;
        if (remain == '0) begin
          phase = lz77d_pkg::PH_CTRL;
          if (ending) begin
            r.out_last = 1'b1;
            block_reset();
          end
        end
      end
    end else if (phase == lz77d_pkg::PH_COPY) begin
      err = 1'b1;
    end else begin
      c = ctrl_b;
      case (phase)
        lz77d_pkg::PH_LIT: begin
          r.out_byte = b;
          r.out_valid = 1'b1;
          hist_put(b);
          remain--;
          if (remain == '0) phase = lz77d_pkg::PH_CTRL;
        end
        lz77d_pkg::PH_DIST: begin
          if (c[7]) begin
            remain = 33'(c[6:5]) + 33'd3;
            cp_dist = 14'({c[4:0], b}) + 14'd1;
            start_copy();
          end else if (c[7:5] == 3'd2) begin
            remain = 33'(c[4:0]) + 33'd7;
            cp_dist = 14'(b) + 14'd1;
            start_copy();
          end else begin
            cp_dist = 14'({c[4:0], b}) + 14'd1;
            phase = lz77d_pkg::PH_SEL;
          end
        end
        lz77d_pkg::PH_SEL: begin
          remain = '0;
          if (b == 8'hFE) begin
            ctrl_b = 8'hFE;
            phase = lz77d_pkg::PH_C4C;
          end else if (b == 8'hFF) begin
            ctrl_b = 8'hFF;
            phase = lz77d_pkg::PH_C4A;
          end else begin
            remain = 33'(b) + 33'd7;
            start_copy();
          end
        end
        lz77d_pkg::PH_C4A, lz77d_pkg::PH_C4B, lz77d_pkg::PH_C4C, lz77d_pkg::PH_CNT1: begin
          remain = {1'b0, remain[23:0], b};
          if (phase != lz77d_pkg::PH_CNT1) begin
            phase = lz77d_pkg::phase_t'(phase + 4'd1);
          end else if (c == 8'h1D) begin
            remain += 33'h1E;
            start_literal();
          end else if (c == 8'h1E) begin
            remain += 33'h11E;
            start_literal();
          end else if (c == 8'h1F) begin
            start_literal();
          end else if (c == 8'hFE) begin
            remain += 33'h105;
            start_copy();
          end else begin
            remain += 33'd3;
            start_copy();
          end
        end
        default: begin
          ctrl_b = b;
          remain = '0;
          if (b < 8'h1D) begin
            remain = 33'(b) + 33'd1;
            start_literal();
          end else if (b == 8'h1D) begin
            phase = lz77d_pkg::PH_CNT1;
          end else if (b == 8'h1E) begin
            phase = lz77d_pkg::PH_C4C;
          end else if (b == 8'h1F) begin
            phase = lz77d_pkg::PH_C4A;
          end else if (b[7:5] == 3'd1) begin
            remain = 33'(b[1:0]) + 33'd3;
            cp_dist = 14'(b[4:2]) + 14'd1;
            start_copy();
          end else begin
            phase = lz77d_pkg::PH_DIST;
          end
        end
      endcase
      if (it.last_of_block) begin
        if (phase == lz77d_pkg::PH_COPY) begin
          ending = 1'b1;
        end else begin
          if (phase != lz77d_pkg::PH_CTRL) err = 1'b1;
          r.out_last = r.out_valid;
          block_reset();
        end
      end
    end
    r.wants_input = (phase != lz77d_pkg::PH_COPY);
    r.error_flag = err;
    return r;
  endfunction

  // stimulus generation derives copy lengths from the tokens it builds and queues each item
  function automatic void add_item(input logic op, input logic [7:0] b, input logic l);
    lz77d_pkg::in_item_t it;
    it.opcode = op;
    it.in_byte = b;
    it.last_of_block = l;
    pending_items.push_back(it);
  endfunction

  function automatic void feed(input logic [7:0] b, input logic l = 1'b0);
    add_item(lz77d_pkg::OP_FEED, b, l);
  endfunction

  function automatic void drains(input int n);
    for (int i = 0; i < n; i++) add_item(lz77d_pkg::OP_DRAIN, 8'($urandom), 1'($urandom));
  endfunction

  // random well-formed block: literal runs and copies of bounded size
  function automatic void random_block(input int tokens);
    int made;
    int kind, n, d, lim;
    made = 0;
    for (int t = 0; t < tokens; t++) begin
      bit fin;
      fin = (t == tokens - 1);
      kind = (made < 2) ? 0 : $urandom_range(0, 5);
      lim = (made > 8191) ? 8191 : made;
      case (kind)
        0: begin
          n = $urandom_range(1, 29);
          feed(8'(n - 1));
          for (int i = 0; i < n; i++) feed(8'($urandom), fin && i == n - 1);
          made += n;
        end
        1: begin
          n = $urandom_range(0, 3);
          d = $urandom_range(1, (lim < 8) ? lim : 8);
          feed({3'b001, 3'(d - 1), 2'(n)}, fin);
          drains(n + 3);
          made += n + 3;
        end
        2: begin
          n = $urandom_range(0, 3);
          d = $urandom_range(1, lim);
          feed({1'b1, 2'(n), 5'((d - 1) >> 8)});
          feed(8'(d - 1), fin);
          drains(n + 3);
          made += n + 3;
        end
        3: begin
          n = $urandom_range(0, 31);
          d = $urandom_range(1, (lim < 256) ? lim : 256);
          feed({3'b010, 5'(n)});
          feed(8'(d - 1), fin);
          drains(n + 7);
          made += n + 7;
        end
        4: begin
          n = $urandom_range(0, 20);
          d = $urandom_range(1, lim);
          feed({3'b011, 5'((d - 1) >> 8)});
          feed(8'(d - 1));
          feed(8'(n), fin);
          drains(n + 7);
          made += n + 7;
        end
        default: begin
          n = $urandom_range(0, 10);
          feed(8'h1D);
          feed(8'(n));
          for (int i = 0; i < n + 30; i++) feed(8'($urandom), fin && i == n + 29);
          made += n + 30;
        end
      endcase
    end
  endfunction

  function automatic int backlog();
    return pending_items.size() + expected_results.size();
  endfunction

  initial begin
    for (int i = 0; i < lz77d_pkg::WindowBytes; i++) hist_mem[i] = '0;
    ctrl_b = '0;
    cp_dist = '0;
    err = 1'b0;
    block_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: drain with nothing pending, literals at extremes
    drains(1);
    feed(8'h00); feed(8'hFF);
    feed(8'h02); feed(8'h00); feed(8'hA5); feed(8'h5A);
    feed(8'h20); drains(3);                          // short copy, distance one
    feed(8'hE0); feed(8'h03); drains(6);             // long-form copy
    feed(8'h5F); feed(8'h00); drains(38);            // medium copy
    feed(8'h1F); feed(8'h00); feed(8'h00); feed(8'h00); feed(8'h00);  // zero run
    feed(8'h60); feed(8'h00); feed(8'hFE); feed(8'h00); feed(8'h00);
    drains(261);                                     // 0xFE selector
    feed(8'h60); feed(8'h00); feed(8'hFF); feed(8'h00); feed(8'h00); feed(8'h00);
    feed(8'h01, 1'b1); drains(4);                    // 0xFF selector, ends block
    feed(8'h3C);                                     // distance beyond produced
    feed(8'h00); feed(8'h11, 1'b1);
    feed(8'h00); feed(8'h20); feed(8'h77); drains(1);  // drain outside a copy
    drains(2);
    feed(8'h1E); feed(8'h00); feed(8'h00); feed(8'hCC); feed(8'h33);
    for (int i = 0; i < 282; i++) feed(8'($urandom));
    feed(8'h1E, 1'b1);                               // truncated token
    feed(8'h05); feed(8'h12, 1'b1);                  // truncated literal run
    while (backlog() != 0) @(posedge clk);

    // random blocks; noise between some of them
    while (pending_items.size() < 300) begin
      random_block($urandom_range(2, 12));
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < $urandom_range(1, 6); i++) begin
          add_item(1'($urandom), 8'($urandom), 1'($urandom));
        end
        feed(8'h00); feed(8'h00, 1'b1);
      end
      if ($urandom_range(0, 9) == 0) add_item(lz77d_pkg::OP_FEED, 8'h00, 1'b1);
    end
    while (backlog() != 0) @(posedge clk);
    quiet = 1'b1;
    for (int k = 0; k < 2; k++) random_block($urandom_range(2, 12));
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(decode_item(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
          in_gap = $urandom_range(1, 13);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected transfer", 32'(out_data), 32'd0);
        end else begin
          lz77d_pkg::out_item_t w;
          w = expected_results.pop_front();
          if (out_data.out_byte !== w.out_byte)
            report("out_byte", 32'(out_data.out_byte), 32'(w.out_byte));
          if (out_data.out_valid !== w.out_valid)
            report("out_valid", 32'(out_data.out_valid), 32'(w.out_valid));
          if (out_data.out_last !== w.out_last)
            report("out_last", 32'(out_data.out_last), 32'(w.out_last));
          if (out_data.wants_input !== w.wants_input)
            report("wants_input", 32'(out_data.wants_input), 32'(w.wants_input));
          if (out_data.error_flag !== w.error_flag)
            report("error_flag", 32'(out_data.error_flag), 32'(w.error_flag));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        out_gap = $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> lz77_variant_decompressor.f
src/lz77d_pkg.sv
src/lz77d_ram.sv
src/lz77d_parser.sv
src/lz77_variant_decompressor.sv
src/lz77d_checker.sv
tb/sv/tb_lz77_variant_decompressor.sv
